// ===== rtl/uart_receiver_from_pulse_widths_unit_assert.svh =====
// Assertion macros for the pulse-width UART receiver checker.
// Depends on nothing; included by the checker file only.
`ifndef UART_RECEIVER_FROM_PULSE_WIDTHS_UNIT_ASSERT_SVH
`define UART_RECEIVER_FROM_PULSE_WIDTHS_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define UARTPW_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define UARTPW_CHECK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/uartpw_pkg.sv =====
// Package for the pulse-width UART receiver: widths, reset values, codes and types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package uartpw_pkg;

   localparam int unsigned TICK_W     = 16;
   localparam int unsigned HALF_W     = 15;
   localparam int unsigned DUR_W      = 15;
   localparam int unsigned ELAPSED_W  = 24;
   localparam int unsigned END_W      = 25;
   localparam int unsigned BITS_W     = 4;
   localparam int unsigned SHIFT_W    = 13;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned DW_W       = 4;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned STOP_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0] BIT_TICKS_RESET   = 16'd174;
   localparam logic [DW_W-1:0]   DATA_WIDTH_RESET  = 4'd8;
   localparam logic [MODE_W-1:0] PARITY_MODE_RESET = 2'd0;
   localparam logic [STOP_W-1:0] STOP_COUNT_RESET  = 2'd1;

   localparam logic [TICK_W-1:0] BIT_TICKS_MIN  = 16'd2;
   localparam logic [DW_W-1:0]   DATA_WIDTH_MIN = 4'd5;
   localparam logic [DW_W-1:0]   DATA_WIDTH_MAX = 4'd8;
   localparam logic [STOP_W-1:0] STOP_COUNT_MIN = 2'd1;
   localparam logic [STOP_W-1:0] STOP_COUNT_MAX = 2'd2;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
   localparam logic [SHIFT_W-1:0]   SHIFT_ONES  = {SHIFT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BIT_TICKS   = 2'd0,
      REG_DATA_WIDTH  = 2'd1,
      REG_PARITY_MODE = 2'd2,
      REG_STOP_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      PARITY_NONE = 2'd0,
      PARITY_EVEN = 2'd1,
      PARITY_ODD  = 2'd2
   } parity_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM,
      ST_DECIDE,
      ST_COUNT,
      ST_APPLY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] bit_ticks;
      logic [HALF_W-1:0] half_ticks;
      logic [DW_W-1:0]   data_width;
      parity_type        parity;
      logic [BITS_W-1:0] frame_len;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [END_W-1:0]   target;
      logic [BITS_W-1:0]  limit;
   } mid_ctl_type;

   typedef struct packed {
      logic              done;
      logic [BITS_W-1:0] count;
   } mid_sts_type;

endpackage

`default_nettype wire

// ===== rtl/uart_receiver_from_pulse_widths_unit.sv =====
// A pulse passes ST_CHECK, ST_SUM, ST_DECIDE and ST_APPLY, then ST_EMIT when it closes a frame;
// a pulse longer than half a bit time also waits in ST_COUNT for the midpoint counter.
// A high pulse before any bit of a frame is dropped in ST_CHECK. A finished frame is
// offered on rsp_ once the result register is free; one pulse is in work at a time.
// Reset is synchronous: it clears the frame, the sequencer and the valid flag of the result register.
// Top level of the pulse-width UART receiver; depends on uartpw_pkg, uartpw_csr, uartpw_midcount.
`default_nettype none

module uart_receiver_from_pulse_widths_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [15:0]                          req_tdata,  // line_level, pulse_ticks
   input  wire logic [0:0]                           req_tuser,  // batch_start
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [7:0]                                rsp_tdata,  // rx_data
   output logic [0:0]                                rsp_tuser,  // parity_error
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [uartpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [uartpw_pkg::CSR_DATA_W-1:0]    csr_data
);

   uartpw_pkg::cfg_type      cfg;
   uartpw_pkg::mid_ctl_type  mid_ctl;
   uartpw_pkg::mid_sts_type  mid_sts;

   uartpw_pkg::state_type    state_ff, state_in;

   logic                                level_ff, level_in;
   logic [uartpw_pkg::DUR_W-1:0]        dur_ff, dur_in;
   logic [uartpw_pkg::BITS_W-1:0]       bits_ff, bits_in;
   logic [uartpw_pkg::SHIFT_W-1:0]      shift_ff, shift_in;
   logic [uartpw_pkg::ELAPSED_W-1:0]    elapsed_ff, elapsed_in;
   logic [uartpw_pkg::END_W-1:0]        end_ff, end_in;
   logic [uartpw_pkg::BITS_W-1:0]       rb_ff, rb_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [uartpw_pkg::DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                                rsp_err_ff, rsp_err_in;

   logic                                accept;
   logic                                load;
   logic [uartpw_pkg::BITS_W-1:0]       left;
   logic [uartpw_pkg::BITS_W-1:0]       rb_clamped;
   logic [uartpw_pkg::BITS_W-1:0]       bits_next;
   logic [uartpw_pkg::SHIFT_W-1:0]      set_mask;
   logic [uartpw_pkg::END_W-1:0]        half_ext;
   logic [uartpw_pkg::DATA_W:0]         data_mask;
   logic [uartpw_pkg::DATA_W-1:0]       data_bits;
   logic [uartpw_pkg::BITS_W-1:0]       par_idx;
   logic                                par_bit;
   logic                                par_calc;
   logic                                par_err;

   uartpw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uartpw_midcount u_midcount (
      .clock (clock),
      .reset (reset),
      .ctl   (mid_ctl),
      .step  (cfg.bit_ticks),
      .sts   (mid_sts)
   );

   assign req_tready = (state_ff == uartpw_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   assign left       = cfg.frame_len - bits_ff;
   assign rb_clamped = (rb_ff > left) ? left : rb_ff;
   assign bits_next  = bits_ff + rb_clamped;
   assign set_mask   = (uartpw_pkg::SHIFT_ONES << bits_ff)
                       & ~(uartpw_pkg::SHIFT_ONES << bits_next);
   assign half_ext   = {{(uartpw_pkg::END_W-uartpw_pkg::HALF_W){1'b0}}, cfg.half_ticks};

   assign data_mask  = (9'd1 << cfg.data_width) - 9'd1;
   assign data_bits  = shift_ff[uartpw_pkg::DATA_W:1] & data_mask[uartpw_pkg::DATA_W-1:0];
   assign par_idx    = cfg.data_width + 4'd1;
   assign par_bit    = shift_ff[par_idx];
   assign par_calc   = ^data_bits;

   always_comb begin
      unique case (cfg.parity)
         uartpw_pkg::PARITY_EVEN: par_err = (par_calc != par_bit);
         uartpw_pkg::PARITY_ODD:  par_err = (par_calc == par_bit);
         default:                 par_err = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      dur_in        = dur_ff;
      bits_in       = bits_ff;
      shift_in      = shift_ff;
      elapsed_in    = elapsed_ff;
      end_in        = end_ff;
      rb_in         = rb_ff;
      mid_ctl.start = 1'b0;
      mid_ctl.target = end_ff - half_ext;
      mid_ctl.limit = cfg.frame_len;
      load          = 1'b0;

      unique case (state_ff)
         uartpw_pkg::ST_IDLE: begin
            if (accept) begin
               level_in = req_tdata[0];
               dur_in   = req_tdata[15:1];
               if (req_tuser[0]) begin
                  bits_in    = '0;
                  shift_in   = '0;
                  elapsed_in = '0;
               end
               state_in = uartpw_pkg::ST_CHECK;
            end
         end
         uartpw_pkg::ST_CHECK: begin
            if (bits_ff == '0 && level_ff) begin
               state_in = uartpw_pkg::ST_IDLE;
            end else begin
               if (bits_ff >= cfg.frame_len) begin
                  bits_in    = '0;
                  shift_in   = '0;
                  elapsed_in = '0;
               end
               state_in = uartpw_pkg::ST_SUM;
            end
         end
         uartpw_pkg::ST_SUM: begin
            end_in   = {1'b0, elapsed_ff}
                       + {{(uartpw_pkg::END_W-uartpw_pkg::DUR_W){1'b0}}, dur_ff};
            state_in = uartpw_pkg::ST_DECIDE;
         end
         uartpw_pkg::ST_DECIDE: begin
            priority if (dur_ff == '0) begin
               rb_in    = left;
               state_in = uartpw_pkg::ST_APPLY;
            end else if (dur_ff <= cfg.half_ticks) begin
               rb_in    = 4'd1;
               state_in = uartpw_pkg::ST_APPLY;
            end else if (end_ff > half_ext) begin
               mid_ctl.start = 1'b1;
               state_in      = uartpw_pkg::ST_COUNT;
            end else begin
               rb_in    = '0;
               state_in = uartpw_pkg::ST_APPLY;
            end
         end
         uartpw_pkg::ST_COUNT: begin
            if (mid_sts.done) begin
               rb_in    = (mid_sts.count > bits_ff) ? (mid_sts.count - bits_ff) : '0;
               state_in = uartpw_pkg::ST_APPLY;
            end
         end
         uartpw_pkg::ST_APPLY: begin
            if (level_ff) begin
               shift_in = shift_ff | set_mask;
            end
            bits_in    = bits_next;
            elapsed_in = end_ff[uartpw_pkg::ELAPSED_W] ? uartpw_pkg::ELAPSED_MAX
                                                       : end_ff[uartpw_pkg::ELAPSED_W-1:0];
            state_in   = (bits_next >= cfg.frame_len) ? uartpw_pkg::ST_EMIT
                                                      : uartpw_pkg::ST_IDLE;
         end
         uartpw_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load       = 1'b1;
               bits_in    = '0;
               shift_in   = '0;
               elapsed_in = '0;
               state_in   = uartpw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uartpw_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = load ? data_bits : rsp_data_ff;
   assign rsp_err_in   = load ? par_err : rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uartpw_pkg::ST_IDLE;
         bits_ff      <= '0;
         shift_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff    <= level_in;
      dur_ff      <= dur_in;
      end_ff      <= end_in;
      rb_ff       <= rb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

endmodule

`default_nettype wire

// ===== rtl/uartpw_csr.sv =====
// Configuration registers of the pulse-width UART receiver and their effective values.
// Depends on uartpw_pkg.
`default_nettype none

module uartpw_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [uartpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [uartpw_pkg::CSR_DATA_W-1:0]    csr_data,
   output uartpw_pkg::cfg_type                       cfg
);

   logic [uartpw_pkg::TICK_W-1:0] bit_ticks_ff, bit_ticks_in;
   logic [uartpw_pkg::DW_W-1:0]   data_width_ff, data_width_in;
   logic [uartpw_pkg::MODE_W-1:0] parity_mode_ff, parity_mode_in;
   logic [uartpw_pkg::STOP_W-1:0] stop_count_ff, stop_count_in;

   logic [uartpw_pkg::TICK_W-1:0] bt_eff;
   logic [uartpw_pkg::DW_W-1:0]   dw_eff;
   logic [uartpw_pkg::STOP_W-1:0] stop_eff;
   uartpw_pkg::parity_type        par_eff;

   assign csr_ready = 1'b1;

   always_comb begin
      bit_ticks_in   = bit_ticks_ff;
      data_width_in  = data_width_ff;
      parity_mode_in = parity_mode_ff;
      stop_count_in  = stop_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (uartpw_pkg::csr_index_type'(csr_index))
            uartpw_pkg::REG_BIT_TICKS:   bit_ticks_in   = csr_data;
            uartpw_pkg::REG_DATA_WIDTH:  data_width_in  = csr_data[uartpw_pkg::DW_W-1:0];
            uartpw_pkg::REG_PARITY_MODE: parity_mode_in = csr_data[uartpw_pkg::MODE_W-1:0];
            uartpw_pkg::REG_STOP_COUNT:  stop_count_in  = csr_data[uartpw_pkg::STOP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff   <= uartpw_pkg::BIT_TICKS_RESET;
         data_width_ff  <= uartpw_pkg::DATA_WIDTH_RESET;
         parity_mode_ff <= uartpw_pkg::PARITY_MODE_RESET;
         stop_count_ff  <= uartpw_pkg::STOP_COUNT_RESET;
      end else begin
         bit_ticks_ff   <= bit_ticks_in;
         data_width_ff  <= data_width_in;
         parity_mode_ff <= parity_mode_in;
         stop_count_ff  <= stop_count_in;
      end
   end

   always_comb begin
      bt_eff = (bit_ticks_ff < uartpw_pkg::BIT_TICKS_MIN) ? uartpw_pkg::BIT_TICKS_MIN
                                                          : bit_ticks_ff;
      priority if (data_width_ff < uartpw_pkg::DATA_WIDTH_MIN) begin
         dw_eff = uartpw_pkg::DATA_WIDTH_MIN;
      end else if (data_width_ff > uartpw_pkg::DATA_WIDTH_MAX) begin
         dw_eff = uartpw_pkg::DATA_WIDTH_MAX;
      end else begin
         dw_eff = data_width_ff;
      end
      priority if (stop_count_ff < uartpw_pkg::STOP_COUNT_MIN) begin
         stop_eff = uartpw_pkg::STOP_COUNT_MIN;
      end else if (stop_count_ff > uartpw_pkg::STOP_COUNT_MAX) begin
         stop_eff = uartpw_pkg::STOP_COUNT_MAX;
      end else begin
         stop_eff = stop_count_ff;
      end
      unique case (parity_mode_ff)
         uartpw_pkg::PARITY_EVEN: par_eff = uartpw_pkg::PARITY_EVEN;
         uartpw_pkg::PARITY_ODD:  par_eff = uartpw_pkg::PARITY_ODD;
         default:                 par_eff = uartpw_pkg::PARITY_NONE;
      endcase

      cfg.bit_ticks  = bt_eff;
      cfg.half_ticks = bt_eff[uartpw_pkg::TICK_W-1:1];
      cfg.data_width = dw_eff;
      cfg.parity     = par_eff;
      cfg.frame_len  = 4'd1 + dw_eff
                       + {3'b000, (par_eff != uartpw_pkg::PARITY_NONE)}
                       + {2'b00, stop_eff};
   end

endmodule

`default_nettype wire

// ===== rtl/uartpw_midcount.sv =====
// Add-and-compare unit that counts bit midpoints, one bit time per cycle.
// It gives the ceiling of target over step, held at the limit. Depends on uartpw_pkg.
`default_nettype none

module uartpw_midcount (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire uartpw_pkg::mid_ctl_type           ctl,
   input  wire logic [uartpw_pkg::TICK_W-1:0]     step,
   output uartpw_pkg::mid_sts_type                sts
);

   logic                            run_ff, run_in;
   logic [uartpw_pkg::END_W-1:0]    acc_ff, acc_in;
   logic [uartpw_pkg::END_W-1:0]    target_ff, target_in;
   logic [uartpw_pkg::BITS_W-1:0]   count_ff, count_in;
   logic [uartpw_pkg::BITS_W-1:0]   limit_ff, limit_in;
   logic                            finished;

   assign finished  = (acc_ff >= target_ff) || (count_ff == limit_ff);
   assign sts.done  = run_ff && finished;
   assign sts.count = count_ff;

   always_comb begin
      run_in    = run_ff;
      acc_in    = acc_ff;
      target_in = target_ff;
      count_in  = count_ff;
      limit_in  = limit_ff;
      if (ctl.start) begin
         run_in    = 1'b1;
         acc_in    = '0;
         count_in  = '0;
         target_in = ctl.target;
         limit_in  = ctl.limit;
      end else if (run_ff) begin
         if (finished) begin
            run_in = 1'b0;
         end else begin
            acc_in   = acc_ff + {{(uartpw_pkg::END_W-uartpw_pkg::TICK_W){1'b0}}, step};
            count_in = count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      acc_ff    <= acc_in;
      target_ff <= target_in;
      count_ff  <= count_in;
      limit_ff  <= limit_in;
   end

endmodule

`default_nettype wire

// ===== rtl/uartpw_checker.sv =====
// Port-level checker for the pulse-width UART receiver, bound to the top level.
// Depends on uart_receiver_from_pulse_widths_unit_assert.svh and uartpw_pkg.
`default_nettype none

`include "uart_receiver_from_pulse_widths_unit_assert.svh"

module uartpw_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [15:0]                          req_tdata,
   input wire logic [0:0]                           req_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [7:0]                           rsp_tdata,
   input wire logic [0:0]                           rsp_tuser,
   input wire logic                                 csr_valid,
   input wire logic                                 csr_ready,
   input wire logic [uartpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input wire logic [uartpw_pkg::CSR_DATA_W-1:0]    csr_data
);

   `UARTPW_CHECK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "Stalled result item changed or vanished.")
   `UARTPW_CHECK(a_one_item, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "A second item was taken while one is in work.")
   `UARTPW_CHECK(a_no_early_rsp, clock, reset, (req_tvalid && req_tready) |=> !$rose(rsp_tvalid), "A result item appeared directly after an input item.")
   `UARTPW_CHECK_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_tvalid, "Result item offered straight after reset.")

endmodule

bind uart_receiver_from_pulse_widths_unit uartpw_checker u_uartpw_checker (.*);

`default_nettype wire

// ===== dv/tb_uart_receiver_from_pulse_widths_unit.sv =====
// Self-checking testbench for the pulse-width UART receiver: directed pulses, then random frames.
// Results are predicted by a frame decoder kept in the bench, or given by the directed rows, and compared item by item.
// Depends on uartpw_pkg and uart_receiver_from_pulse_widths_unit.
`default_nettype none

module tb_uart_receiver_from_pulse_widths_unit;
   import uartpw_pkg::*;

   localparam int unsigned QUIET_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned NUM_PHASES   = 6;
   localparam logic [MODE_W-1:0] PARITY_SPARE = 2'd3;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_pace_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              par_err;
   } rx_byte_type;

   typedef struct packed {
      logic                  is_cfg;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
      logic                  level;
      logic [DUR_W-1:0]      ticks;
      logic                  batch;
      logic                  typed;
      rx_byte_type           want;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index  = REG_BIT_TICKS;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Decoder copy of the registers and of the frame being collected.
   logic [TICK_W-1:0]  cfg_bit_ticks  = BIT_TICKS_RESET;
   logic [DW_W-1:0]    cfg_data_width = DATA_WIDTH_RESET;
   logic [MODE_W-1:0]  cfg_parity     = PARITY_MODE_RESET;
   logic [STOP_W-1:0]  cfg_stop       = STOP_COUNT_RESET;
   int                 seen_bits      = 0;
   logic [SHIFT_W-1:0] shift_bits     = '0;
   int                 elapsed        = 0;

   rx_byte_type expected_bytes[$];

   int          fail_count     = 0;
   int          pulses_sent    = 0;
   int          pulses_counted = 0;
   int          frames_checked = 0;
   int          frames_flagged = 0;
   int          burst_left     = 0;
   bit          gaps_on        = 1'b1;
   rx_pace_type rx_mode        = RX_RANDOM;
   logic        hold_toggle    = 1'b0;
   logic        hold_seen      = 1'b0;
   int          hold_left      = 0;
   int          rx_tick        = 0;

   uart_receiver_from_pulse_widths_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // line_level, pulse_ticks
      .req_tuser  (req_tuser),   // batch_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // rx_data
      .rsp_tuser  (rsp_tuser),   // parity_error
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      #5000000;
      $display("tb_uart_receiver_from_pulse_widths_unit: done, errors");
      $finish;
   end

   function automatic void frame_shape(output int bt, output int dw, output logic has_par,
                                       output int flen);
      int stops;
      bt = (cfg_bit_ticks < BIT_TICKS_MIN) ? int'(BIT_TICKS_MIN) : int'(cfg_bit_ticks);
      if (cfg_data_width < DATA_WIDTH_MIN) dw = int'(DATA_WIDTH_MIN);
      else if (cfg_data_width > DATA_WIDTH_MAX) dw = int'(DATA_WIDTH_MAX);
      else dw = int'(cfg_data_width);
      has_par = (cfg_parity == PARITY_EVEN) || (cfg_parity == PARITY_ODD);
      if (cfg_stop < STOP_COUNT_MIN) stops = int'(STOP_COUNT_MIN);
      else if (cfg_stop > STOP_COUNT_MAX) stops = int'(STOP_COUNT_MAX);
      else stops = int'(cfg_stop);
      flen = 1 + dw + int'(has_par) + stops;
   endfunction

   function automatic void clear_frame();
      seen_bits  = 0;
      shift_bits = '0;
      elapsed    = 0;
   endfunction

   function automatic void decode_pulse(input logic level, input logic [DUR_W-1:0] ticks,
                                        input logic batch, output logic emitted,
                                        output logic ignored, output rx_byte_type res);
      int                bt, half, dw, flen, left, add, upto, fin, i;
      logic              has_par, calc, pbit;
      logic [DATA_W-1:0] data;
      emitted = 1'b0;
      ignored = 1'b0;
      res     = '0;
      frame_shape(bt, dw, has_par, flen);
      half = bt / 2;
      if (batch) clear_frame();
      if (seen_bits == 0 && level) begin
         ignored = 1'b1;
         return;
      end
      if (seen_bits >= flen) clear_frame();
      left = flen - seen_bits;
      fin  = elapsed + int'(ticks);
      if (ticks == 0) begin
         add = left;
      end else if (int'(ticks) <= half) begin
         add = 1;
      end else if (fin > half) begin
         upto = (fin - half + bt - 1) / bt;
         add  = (upto > seen_bits) ? upto - seen_bits : 0;
      end else begin
         add = 0;
      end
      if (add > left) add = left;
      if (level) begin
         for (i = 0; i < add; i++) shift_bits[seen_bits + i] = 1'b1;
      end
      seen_bits += add;
      elapsed = (fin > int'(ELAPSED_MAX)) ? int'(ELAPSED_MAX) : fin;
      if (seen_bits >= flen) begin
         data = shift_bits[DATA_W:1] & DATA_W'((1 << dw) - 1);
         calc = ^data;
         pbit = shift_bits[dw + 1];
         res.data = data;
         if (has_par) res.par_err = (cfg_parity == PARITY_EVEN) ? (calc != pbit) : (calc == pbit);
         emitted = 1'b1;
         clear_frame();
      end
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_BIT_TICKS:   cfg_bit_ticks  = val;
         REG_DATA_WIDTH:  cfg_data_width = val[DW_W-1:0];
         REG_PARITY_MODE: cfg_parity     = val[MODE_W-1:0];
         REG_STOP_COUNT:  cfg_stop       = val[STOP_W-1:0];
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   // A pulse that closes no frame may still be in work once the queue is empty.
   task automatic settle();
      drain();
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic send_pulse(input logic level, input logic [DUR_W-1:0] ticks, input logic batch,
                             input logic typed, input rx_byte_type want);
      logic        emitted, ignored;
      rx_byte_type got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on && $urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ticks, level};
      req_tuser  <= batch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      decode_pulse(level, ticks, batch, emitted, ignored, got);
      pulses_sent++;
      if (!ignored) pulses_counted++;
      if (emitted) expected_bytes.push_back(typed ? want : got);
   endtask

   // Run-length codes one frame at the current settings, with timing jitter and the
   // occasional bad parity or low stop bit.
   task automatic send_frame(input logic [DATA_W-1:0] value);
      int   bt, dw, flen, i, j, dur, jit;
      logic has_par, pbit;
      logic lv [0:11];
      bit   zero_end, batch;
      frame_shape(bt, dw, has_par, flen);
      lv[0] = 1'b0;
      pbit  = 1'b0;
      for (i = 0; i < dw; i++) begin
         lv[1 + i] = value[i];
         pbit ^= value[i];
      end
      for (i = 1 + dw; i < flen; i++) lv[i] = ($urandom_range(0, 9) != 0);
      if (has_par) begin
         if (cfg_parity == PARITY_ODD) pbit = ~pbit;
         if ($urandom_range(0, 4) == 0) pbit = ~pbit;
         lv[1 + dw] = pbit;
      end
      zero_end = $urandom_range(0, 1);
      batch    = ($urandom_range(0, 6) == 0);
      jit      = bt / 4;
      i = 0;
      while (i < flen) begin
         j = i;
         while (j < flen && lv[j] == lv[i]) j++;
         dur = (j - i) * bt + int'($urandom_range(0, 2 * jit)) - jit;
         if (dur < 1) dur = 1;
         if (dur > 32767) dur = 32767;
         if (j == flen && zero_end) dur = 0;
         send_pulse(lv[i], DUR_W'(dur), batch && (i == 0), 1'b0, '0);
         i = j;
      end
      if ($urandom_range(0, 4) == 0) send_pulse(1'b1, DUR_W'($urandom_range(1, 500)), 1'b0,
                                                1'b0, '0);
   endtask

   function automatic stim_row_type cfg_row(input csr_index_type idx,
                                            input logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.index  = idx;
      row.value  = val;
      return row;
   endfunction

   function automatic stim_row_type pulse_row(input logic level, input logic [DUR_W-1:0] ticks,
                                              input logic batch, input logic typed,
                                              input rx_byte_type want);
      stim_row_type row;
      row       = '0;
      row.level = level;
      row.ticks = ticks;
      row.batch = batch;
      row.typed = typed;
      row.want  = want;
      return row;
   endfunction

   always @(posedge clock) begin : rx_pace
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      rx_tick++;
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 4) > 1);
            RX_PATTERN: rsp_tready <= ((rx_tick % 7) >= 3);
         endcase
      end
   end

   always @(posedge clock) begin : rx_check
      rx_byte_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         frames_checked++;
         if (rsp_tuser[0]) frames_flagged++;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected item data %h parity_error %b", $time, rsp_tdata,
                     rsp_tuser[0]);
            fail_count++;
         end else begin
            head = expected_bytes.pop_front();
            if (rsp_tdata !== head.data) begin
               $display("%0t: rx_data expected %h actual %h", $time, head.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== head.par_err) begin
               $display("%0t: parity_error expected %b actual %b", $time, head.par_err,
                        rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type          rows[$];
      logic [CSR_DATA_W-1:0] regs [0:3];
      int                    quota [0:NUM_PHASES-1];
      int                    r, p, target;
      bit                    prev_cfg, paused;
      int                    bt, dw, flen;
      logic                  has_par;
      quota = '{80, 80, 80, 40, 90, 80};

      rows.push_back(pulse_row(1'b1, 100, 1'b1, 1'b0, '0));
      rows.push_back(pulse_row(1'b0, 0, 1'b0, 1'b1, {8'h00, 1'b0}));
      rows.push_back(pulse_row(1'b0, 87, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 0, 1'b0, 1'b1, {8'hFF, 1'b0}));
      rows.push_back(pulse_row(1'b0, 174, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 32767, 1'b0, 1'b1, {8'hFF, 1'b0}));
      rows.push_back(cfg_row(REG_PARITY_MODE, 16'(PARITY_EVEN)));
      rows.push_back(pulse_row(1'b0, 87, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 0, 1'b0, 1'b1, {8'hFF, 1'b1}));
      rows.push_back(cfg_row(REG_PARITY_MODE, 16'(PARITY_ODD)));
      rows.push_back(pulse_row(1'b0, 0, 1'b0, 1'b1, {8'h00, 1'b1}));
      rows.push_back(cfg_row(REG_PARITY_MODE, 16'(PARITY_SPARE)));
      rows.push_back(pulse_row(1'b0, 87, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 0, 1'b0, 1'b1, {8'hFF, 1'b0}));
      rows.push_back(cfg_row(REG_DATA_WIDTH, 16'd0));
      rows.push_back(cfg_row(REG_STOP_COUNT, 16'd0));
      rows.push_back(pulse_row(1'b0, 87, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 0, 1'b0, 1'b1, {8'h1F, 1'b0}));
      rows.push_back(cfg_row(REG_DATA_WIDTH, 16'd15));
      rows.push_back(cfg_row(REG_STOP_COUNT, 16'd3));
      rows.push_back(cfg_row(REG_BIT_TICKS, 16'd0));
      rows.push_back(pulse_row(1'b0, 1, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 1, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b0, 1, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 0, 1'b0, 1'b1, {8'hFD, 1'b0}));
      rows.push_back(cfg_row(REG_BIT_TICKS, 16'd1));
      rows.push_back(pulse_row(1'b0, 3, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 4, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b0, 0, 1'b0, 1'b0, '0));
      rows.push_back(cfg_row(REG_BIT_TICKS, 16'd65535));
      rows.push_back(pulse_row(1'b0, 100, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 100, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b0, 0, 1'b1, 1'b1, {8'h00, 1'b0}));
      rows.push_back(cfg_row(REG_BIT_TICKS, 16'd10));
      rows.push_back(cfg_row(REG_DATA_WIDTH, 16'd8));
      rows.push_back(cfg_row(REG_STOP_COUNT, 16'd1));
      rows.push_back(cfg_row(REG_PARITY_MODE, 16'(PARITY_NONE)));
      rows.push_back(pulse_row(1'b0, 10, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b1, 80, 1'b0, 1'b0, '0));
      rows.push_back(pulse_row(1'b0, 10, 1'b0, 1'b0, '0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      prev_cfg = 1'b0;
      for (r = 0; r < rows.size(); r++) begin
         if (rows[r].is_cfg) begin
            if (!prev_cfg) settle();
            write_reg(rows[r].index, rows[r].value);
         end else begin
            if (prev_cfg) csr_valid <= 1'b0;
            send_pulse(rows[r].level, rows[r].ticks, rows[r].batch, rows[r].typed,
                       rows[r].want);
         end
         prev_cfg = rows[r].is_cfg;
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0: regs = '{16'd16, 16'd8, 16'(PARITY_NONE), 16'd1};
            1: regs = '{16'd2, 16'd5, 16'(PARITY_EVEN), 16'd2};
            2: regs = '{16'($urandom_range(20, 300)), 16'($urandom_range(5, 8)),
                        16'(PARITY_ODD), 16'd1};
            3: regs = '{16'd65535, 16'd8, 16'(PARITY_ODD), 16'd2};
            4: regs = '{16'($urandom_range(0, 400)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
            default: regs = '{16'd100, 16'd7, 16'(PARITY_EVEN), 16'd2};
         endcase
         write_reg(REG_BIT_TICKS, regs[0]);
         write_reg(REG_DATA_WIDTH, regs[1]);
         write_reg(REG_PARITY_MODE, regs[2]);
         write_reg(REG_STOP_COUNT, regs[3]);
         csr_valid <= 1'b0;
         case (p)
            0:       rx_mode <= RX_ALWAYS;
            2, 5:    rx_mode <= RX_PATTERN;
            default: rx_mode <= RX_RANDOM;
         endcase
         gaps_on = (p != 0) && (p != 5);
         // The receiver holds off here while frames keep coming, so the input backs up.
         if (p == 2) hold_toggle <= ~hold_toggle;
         paused = 1'b0;
         target = pulses_counted + quota[p];
         frame_shape(bt, dw, has_par, flen);
         while (pulses_counted < target) begin
            if (p == 5 && !paused && pulses_counted >= target - quota[p] / 2) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 4) != 0) begin
               send_frame(DATA_W'($urandom_range(0, 255)));
            end else begin
               case ($urandom_range(0, 9))
                  0, 1:    send_pulse($urandom_range(0, 1), '0, $urandom_range(0, 9) == 0,
                                      1'b0, '0);
                  2, 3, 4: send_pulse($urandom_range(0, 1), DUR_W'($urandom_range(0, 32767)),
                                      $urandom_range(0, 9) == 0, 1'b0, '0);
                  default: send_pulse($urandom_range(0, 1),
                                      DUR_W'($urandom_range(1, (3 * bt > 32767) ? 32767 : 3 * bt)),
                                      $urandom_range(0, 9) == 0, 1'b0, '0);
               endcase
            end
         end
      end
      settle();

      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, expected_bytes.size());
         fail_count++;
      end
      $display("Sent %0d pulses (%0d not skipped) over %0d register settings plus the directed set.",
               pulses_sent, pulses_counted, NUM_PHASES);
      $display("Checked %0d received bytes, %0d of them flagged with a parity error.",
               frames_checked, frames_flagged);
      if (fail_count == 0) begin
         $display("tb_uart_receiver_from_pulse_widths_unit: done, clean");
      end else begin
         $display("tb_uart_receiver_from_pulse_widths_unit: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
